### src/sacc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the set-associative cache hit/miss model
// no dependencies

package sacc_pkg;

  localparam int CNT_W  = 32;
  localparam int ADDR_W = 32;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              mode;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             writeback;
    logic [CNT_W-1:0] access_count;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] read_miss_count;
    logic [CNT_W-1:0] write_miss_count;
    logic [CNT_W-1:0] writeback_count;
  } rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

### src/sacc_front.sv
`timescale 1ns / 1ps
// front end: takes an access word and splits the block number into set and tag
// depends on sacc_pkg; feeds sacc_queue

module sacc_front #(
  parameter int NUM_SETS    = 64,
  parameter int OFFSET_BITS = 5,
  parameter int ADDR_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sacc_pkg::req_t      req,
  output logic                push_valid,
  input  logic                push_ready,
  output logic [1+((($clog2(NUM_SETS) > 0) ? $clog2(NUM_SETS) : 1))
                 +((((ADDR_BITS-OFFSET_BITS)-($clog2(NUM_SETS+1)-1)) > 0)
                   ? ((ADDR_BITS-OFFSET_BITS)-($clog2(NUM_SETS+1)-1)) : 1)-1:0] push_data
);
  import sacc_pkg::*;

  localparam int BLK_W     = ADDR_BITS - OFFSET_BITS;
  localparam int LOG2S     = $clog2(NUM_SETS);
  localparam int FLOORLOG  = $clog2(NUM_SETS + 1) - 1;
  localparam bit SETS_POW2 = (NUM_SETS == (1 << LOG2S));
  localparam int SIDX_W    = (LOG2S > 0) ? LOG2S : 1;
  localparam int TAG_RAW   = BLK_W - FLOORLOG;
  localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int RCP_W     = BLK_W + 1;
  localparam int PROD_W    = BLK_W + RCP_W;
  localparam int RCP_SH    = BLK_W + LOG2S;
  // ceil(2^(BLK_W+LOG2S) / NUM_SETS) gives the exact quotient for every block number
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << RCP_SH) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

  logic              busy;
  logic              cnt;
  logic [BLK_W-1:0]  blk;
  logic [BLK_W-1:0]  quo;
  logic              mode;

  logic              take;
  logic              push_fire;
  logic [PROD_W-1:0] prod;
  logic [BLK_W-1:0]  quo_calc;
  logic [BLK_W-1:0]  blk_rem;
  logic [SIDX_W-1:0] set_idx;
  logic [TAG_W-1:0]  tag;

  assign push_valid = busy && !cnt;
  assign push_fire  = push_valid && push_ready;
  assign req_ready  = !busy || push_fire;
  assign take       = req_valid && req_ready;

  // quotient by reciprocal multiply when the set count is not a power of two
  assign prod     = PROD_W'(blk) * PROD_W'(RCP);
  assign quo_calc = BLK_W'(prod >> RCP_SH);
  assign blk_rem  = blk - quo * BLK_W'(NUM_SETS);

  always_comb begin
    if (SETS_POW2) begin
      set_idx = SIDX_W'(blk & BLK_W'(NUM_SETS - 1));
      tag     = TAG_W'(blk >> LOG2S);
    end else begin
      set_idx = SIDX_W'(blk_rem);
      tag     = TAG_W'(quo);
    end
  end

  assign push_data = {mode, set_idx, tag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= !SETS_POW2;
    end else if (push_fire) begin
      busy <= 1'b0;
    end else if (busy && cnt) begin
      cnt <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      blk  <= req.address[ADDR_BITS-1:OFFSET_BITS];
      mode <= req.mode;
    end
    if (busy && cnt) quo <= quo_calc;
  end

endmodule

### src/sacc_queue.sv
`timescale 1ns / 1ps
// two-entry queue between the front end and the lookup back end
// no dependencies

module sacc_queue #(
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

### src/sacc_back.sv
`timescale 1ns / 1ps
// back end: set row memory, hit/victim selection, counters and result register
// depends on sacc_pkg; fed by sacc_queue

module sacc_back #(
  parameter int NUM_SETS    = 64,
  parameter int WAYS        = 4,
  parameter int OFFSET_BITS = 5,
  parameter int ADDR_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  logic [1+((($clog2(NUM_SETS) > 0) ? $clog2(NUM_SETS) : 1))
                 +((((ADDR_BITS-OFFSET_BITS)-($clog2(NUM_SETS+1)-1)) > 0)
                   ? ((ADDR_BITS-OFFSET_BITS)-($clog2(NUM_SETS+1)-1)) : 1)-1:0] pop_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sacc_pkg::rsp_t      rsp
);
  import sacc_pkg::*;

  localparam int BLK_W    = ADDR_BITS - OFFSET_BITS;
  localparam int LOG2S    = $clog2(NUM_SETS);
  localparam int FLOORLOG = $clog2(NUM_SETS + 1) - 1;
  localparam int SIDX_W   = (LOG2S > 0) ? LOG2S : 1;
  localparam int TAG_RAW  = BLK_W - FLOORLOG;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int WAY_W    = ($clog2(WAYS) > 0) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  row_t mem [NUM_SETS];
  row_t rdata;

  logic [SIDX_W-1:0] clr_idx;
  logic [SIDX_W-1:0] cur_set;
  logic [TAG_W-1:0]  cur_tag;
  logic              cur_mode;

  logic [CNT_W-1:0] access_cnt;
  logic [CNT_W-1:0] read_cnt;
  logic [CNT_W-1:0] write_cnt;
  logic [CNT_W-1:0] read_miss_cnt;
  logic [CNT_W-1:0] write_miss_cnt;
  logic [CNT_W-1:0] writeback_cnt;

  logic [SIDX_W-1:0] q_set;
  logic [TAG_W-1:0]  q_tag;
  logic              q_mode;

  logic             pop_fire;
  logic             fire;
  logic             hit;
  logic             have_free;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic             wb;
  row_t             new_row;
  logic             mem_we;
  logic [SIDX_W-1:0] mem_waddr;
  row_t             mem_wdata;
  rsp_t             rsp_next;

  assign {q_mode, q_set, q_tag} = pop_data;

  assign pop_ready = (state == ST_IDLE);
  assign pop_fire  = pop_valid && pop_ready;
  assign fire      = (state == ST_LOOK) && (!rsp_valid || rsp_ready);

  // lowest invalid way is the free slot, lowest matching valid way the hit
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!rdata[w].valid) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_way  = WAY_W'(w);
        end
      end else if (!hit && rdata[w].tag == cur_tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    new_row = rdata;
    wb      = 1'b0;
    if (hit) begin
      if (cur_mode == MODE_WRITE) new_row[hit_way].dirty = 1'b1;
    end else if (have_free) begin
      new_row[free_way] = '{valid: 1'b1, dirty: cur_mode, tag: cur_tag};
    end else begin
      wb         = rdata[0].dirty;
      new_row[0] = '{valid: 1'b1, dirty: cur_mode, tag: cur_tag};
    end
  end

  always_comb begin
    rsp_next.hit              = hit;
    rsp_next.writeback        = wb;
    rsp_next.access_count     = sat_inc(access_cnt);
    rsp_next.read_count       = (cur_mode == MODE_READ) ? sat_inc(read_cnt) : read_cnt;
    rsp_next.write_count      = (cur_mode == MODE_WRITE) ? sat_inc(write_cnt) : write_cnt;
    rsp_next.read_miss_count  = (!hit && cur_mode == MODE_READ) ?
                                sat_inc(read_miss_cnt) : read_miss_cnt;
    rsp_next.write_miss_count = (!hit && cur_mode == MODE_WRITE) ?
                                sat_inc(write_miss_cnt) : write_miss_cnt;
    rsp_next.writeback_count  = wb ? sat_inc(writeback_cnt) : writeback_cnt;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_set;
    mem_wdata = new_row;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (fire) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == SIDX_W'(NUM_SETS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (pop_fire) state_next = ST_LOOK;
      ST_LOOK:  if (fire) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (pop_fire) rdata <= mem[q_set];
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      cur_set  <= q_set;
      cur_tag  <= q_tag;
      cur_mode <= q_mode;
    end
    if (fire) rsp <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      rsp_valid      <= 1'b0;
      access_cnt     <= '0;
      read_cnt       <= '0;
      write_cnt      <= '0;
      read_miss_cnt  <= '0;
      write_miss_cnt <= '0;
      writeback_cnt  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + SIDX_W'(1);
      if (fire) begin
        rsp_valid      <= 1'b1;
        access_cnt     <= rsp_next.access_count;
        read_cnt       <= rsp_next.read_count;
        write_cnt      <= rsp_next.write_count;
        read_miss_cnt  <= rsp_next.read_miss_count;
        write_miss_cnt <= rsp_next.write_miss_count;
        writeback_cnt  <= rsp_next.writeback_count;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fire_gives_word: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("lookup finished but no result word");

  a_hit_no_writeback: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.writeback))
    else $error("write-back reported on a hit");

  a_read_miss_le_reads: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.read_miss_count <= rsp.read_count))
    else $error("read misses exceed reads");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK && !fire) |=> (state == ST_LOOK) && $stable(cur_set))
    else $error("lookup lost while result register full");
`endif

endmodule

### src/set_assoc_cache_hit_miss_model.sv
`timescale 1ns / 1ps
// top level of the set-associative write-back cache hit/miss model
// depends on sacc_pkg, sacc_front, sacc_queue, sacc_back

// After reset the block sweeps the set memory clear, one set per cycle; meanwhile
// the front end still takes words, up to three (one in its register, two in the
// queue) before it stalls. The front end registers each address, then splits the
// block number into set and tag; when NUM_SETS is not a power of two it first
// registers the quotient of a reciprocal multiply, then forms the remainder. The
// back end reads the set row, then updates it and writes it back, and takes no new
// access until that row is written; it waits while the result register is full. A
// result word passes the front end registers, the queue, the row read and the
// result register. Each access returns one result word with the hit and write-back
// flags and all six saturating counters including this access.

module set_assoc_cache_hit_miss_model #(
  parameter int NUM_SETS    = 64,
  parameter int WAYS        = 4,
  parameter int OFFSET_BITS = 5,
  parameter int ADDR_BITS   = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sacc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sacc_pkg::rsp_t rsp
);
  import sacc_pkg::*;

  localparam int BLK_W    = ADDR_BITS - OFFSET_BITS;
  localparam int LOG2S    = $clog2(NUM_SETS);
  localparam int FLOORLOG = $clog2(NUM_SETS + 1) - 1;
  localparam int SIDX_W   = (LOG2S > 0) ? LOG2S : 1;
  localparam int TAG_RAW  = BLK_W - FLOORLOG;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int Q_W      = 1 + SIDX_W + TAG_W;

  logic           push_valid;
  logic           push_ready;
  logic [Q_W-1:0] push_data;
  logic           pop_valid;
  logic           pop_ready;
  logic [Q_W-1:0] pop_data;

  sacc_front #(
    .NUM_SETS   (NUM_SETS),
    .OFFSET_BITS(OFFSET_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  sacc_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  sacc_back #(
    .NUM_SETS   (NUM_SETS),
    .WAYS       (WAYS),
    .OFFSET_BITS(OFFSET_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule
